>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define TWPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle
`define TWPT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/twpt_pkg.sv
// Package for the time window peak tracker: payload types, sizes,
// register indexes, controller states and control/status structs. No dependencies.
`default_nettype none

package twpt_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned EXT_W  = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned WIN_W  = 32;
  localparam int unsigned SUM_W  = VAL_W + CNT_W;
  localparam int unsigned DCNT_W = $clog2(SUM_W);
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = CFG_IDX_W'(1);

  localparam logic [WIN_W-1:0] WINDOW_RESET   = WIN_W'(60000);
  localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(1024);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic                     command;
    logic signed [VAL_W-1:0]  sample_value;
    logic        [TIME_W-1:0] sample_time;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  max_value;
    logic        [TIME_W-1:0] peak_time;
    logic signed [VAL_W-1:0]  mean_value;
    logic        [CNT_W-1:0]  entry_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP_RD,
    ST_DROP_CHK,
    ST_APPEND,
    ST_SCAN,
    ST_SCAN_END,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;   // latch the accepted item
    logic clear;     // empty the ring
    logic rd_oldest; // read the oldest entry
    logic drop;      // retire the oldest entry
    logic append;    // write the new sample
    logic scan;      // issue one scan read
    logic div_load;  // start the division
    logic div_step;  // one quotient bit
    logic out_load;  // move the result to the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic held_zero;
    logic aged;
    logic scan_last;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/twpt_datapath.sv
// Datapath of the tracker: sample ring memory, ring pointers, scan
// accumulators, serial divider and output register. Uses twpt_pkg.
`default_nettype none
`include "assert_macros.svh"

module twpt_datapath (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [twpt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [twpt_pkg::WIN_W-1:0]     cfg_data_i,
  input  twpt_pkg::in_item_t            in_data_i,
  input  twpt_pkg::ctrl_cmd_t           cmd_i,
  output twpt_pkg::dp_status_t          status_o,
  input  wire                           out_stall_i,
  output logic                          out_valid_o,
  output twpt_pkg::out_item_t           out_data_o
);
  import twpt_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0]  val;
    logic [TIME_W-1:0] tim;
  } entry_t;

  logic [WIN_W-1:0]  win_q;
  logic [CNT_W-1:0]  cap_q;
  logic [EXT_W-1:0]  cap_use;
  logic [ADDR_W-1:0] oldest_q, oldest_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic              is_clear_q;
  logic signed [VAL_W-1:0] sval_q;
  logic [TIME_W-1:0] now_q;

  entry_t            mem [DEPTH];
  entry_t            rd_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_vld_q;
  logic [ADDR_W-1:0] wr_addr;

  logic [CNT_W-1:0]  idx_q;
  logic [ADDR_W-1:0] scan_addr_q;
  logic              first_q;
  logic signed [VAL_W-1:0] peak_q;
  logic [TIME_W-1:0] peak_t_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;

  logic              neg_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [CNT_W:0]    rem_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [CNT_W:0]    rem_t;
  logic [SUM_W-1:0]  quo;

  logic              out_valid_q;
  out_item_t         out_q, res;

  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] s,
                                                  input logic [EXT_W-1:0]  cap);
    logic [EXT_W-1:0] n;
    n = EXT_W'(s) + EXT_W'(1);
    return (n >= cap) ? '0 : n[ADDR_W-1:0];
  endfunction

  // Clamp the capacity register into 1..DEPTH
  always_comb begin
    if (cap_q == '0) begin
      cap_use = EXT_W'(1);
    end else if (32'(cap_q) > DEPTH) begin
      cap_use = EXT_W'(DEPTH);
    end else begin
      cap_use = EXT_W'(cap_q);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WINDOW_RESET;
      cap_q <= CAPACITY_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WINDOW) begin
        win_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_CAPACITY) begin
        cap_q <= cfg_data_i[CNT_W-1:0];
      end
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sval_q <= in_data_i.sample_value;
      now_q  <= in_data_i.sample_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_clear_q <= 1'b0;
    end else if (cmd_i.capture) begin
      is_clear_q <= (in_data_i.command == CMD_CLEAR);
    end
  end

  // Append slot: oldest plus held, wrapped once
  always_comb begin
    logic [EXT_W-1:0] s;
    s = EXT_W'(oldest_q) + EXT_W'(held_q);
    if (s >= cap_use) begin
      s = s - cap_use;
    end
    wr_addr = s[ADDR_W-1:0];
  end

  // Ring pointers
  always_comb begin
    oldest_d = oldest_q;
    held_d   = held_q;
    if ((cfg_we_i && cfg_idx_i == CFG_CAPACITY) || cmd_i.clear) begin
      oldest_d = '0;
      held_d   = '0;
    end else if (cmd_i.drop) begin
      oldest_d = next_slot(oldest_q, cap_use);
      held_d   = held_q - CNT_W'(1);
    end else if (cmd_i.append) begin
      if (EXT_W'(held_q) >= cap_use) begin
        oldest_d = next_slot(oldest_q, cap_use);
      end else begin
        held_d = held_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      held_q   <= '0;
    end else begin
      oldest_q <= oldest_d;
      held_q   <= held_d;
    end
  end

  // Sample memory: one write port, one registered read port
  assign rd_addr = cmd_i.scan ? scan_addr_q : oldest_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem[wr_addr] <= '{val: sval_q, tim: now_q};
    end
    if (cmd_i.scan || cmd_i.rd_oldest) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Scan address and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      idx_q       <= '0;
      scan_addr_q <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.append) begin
        idx_q       <= '0;
        scan_addr_q <= oldest_d;
      end else if (cmd_i.scan) begin
        idx_q       <= idx_q + CNT_W'(1);
        scan_addr_q <= next_slot(scan_addr_q, cap_use);
      end
    end
  end

  // Running sum including the entry now on the read port
  assign sum_d = sum_q + SUM_W'(signed'(rd_q.val));

  // Accumulate sum and peak, earliest entry wins ties
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      first_q <= 1'b1;
      sum_q   <= '0;
    end else if (rd_vld_q) begin
      first_q <= 1'b0;
      sum_q   <= sum_d;
      if (first_q || signed'(rd_q.val) > peak_q) begin
        peak_q   <= signed'(rd_q.val);
        peak_t_q <= rd_q.tim;
      end
    end
  end

  // Restoring divider on magnitudes, one quotient bit a cycle
  always_comb begin
    rem_t = {rem_q[CNT_W-1:0], dvd_q[SUM_W-1]};
  end

  // Load from the full sum: the last scan entry is added in this same cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      neg_q  <= sum_d[SUM_W-1];
      dvd_q  <= sum_d[SUM_W-1] ? SUM_W'(-sum_d) : SUM_W'(sum_d);
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + DCNT_W'(1);
      if (rem_t >= (CNT_W+1)'(held_q)) begin
        rem_q <= rem_t - (CNT_W+1)'(held_q);
        dvd_q <= {dvd_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_t;
        dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo = neg_q ? SUM_W'(-dvd_q) : dvd_q;

  // Result word, zeros after a clear
  always_comb begin
    if (is_clear_q) begin
      res = '0;
    end else begin
      res.max_value   = peak_q;
      res.peak_time   = peak_t_q;
      res.mean_value  = signed'(quo[VAL_W-1:0]);
      res.entry_count = held_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to the controller
  always_comb begin
    status_o.in_clear  = (in_data_i.command == CMD_CLEAR);
    status_o.held_zero = (held_q == '0);
    status_o.aged      = ((TIME_W+1)'(rd_q.tim) + (TIME_W+1)'(win_q)) < (TIME_W+1)'(now_q);
    status_o.scan_last = ((idx_q + CNT_W'(1)) == held_q);
    status_o.div_last  = (dcnt_q == DCNT_W'(SUM_W - 1));
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

  `TWPT_ASSERT(a_held_le_cap, EXT_W'(held_q) <= cap_use, "held count above capacity")
  `TWPT_ASSERT(a_oldest_lt_cap, EXT_W'(oldest_q) < cap_use, "oldest slot outside ring")
  `TWPT_ASSERT(a_scan_nonempty, !rd_vld_q || held_q != '0, "scan read with empty ring")

endmodule

`default_nettype wire

>>> hw/rtl/twpt_ctrl.sv
// Controller of the tracker: sequences drop, append, scan, division
// and output for each sample, and output only for a clear. Uses twpt_pkg.
`default_nettype none
`include "assert_macros.svh"

module twpt_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  twpt_pkg::dp_status_t status_i,
  output twpt_pkg::ctrl_cmd_t  cmd_o
);
  import twpt_pkg::*;

  state_e state_q, state_d;
  logic   in_acc;

  assign in_acc = in_valid_i && (state_q == ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = status_i.in_clear ? ST_DONE : ST_DROP_RD;
        end
      end
      ST_DROP_RD:  state_d = status_i.held_zero ? ST_APPEND : ST_DROP_CHK;
      ST_DROP_CHK: state_d = status_i.aged ? ST_DROP_RD : ST_APPEND;
      ST_APPEND:   state_d = ST_SCAN;
      ST_SCAN:     state_d = status_i.scan_last ? ST_SCAN_END : ST_SCAN;
      ST_SCAN_END: state_d = ST_DIV;
      ST_DIV:      state_d = status_i.div_last ? ST_DONE : ST_DIV;
      ST_DONE:     state_d = status_i.out_free ? ST_IDLE : ST_DONE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.capture = in_acc;
        cmd_o.clear   = in_acc && status_i.in_clear;
      end
      ST_DROP_RD:  cmd_o.rd_oldest = !status_i.held_zero;
      ST_DROP_CHK: cmd_o.drop      = status_i.aged;
      ST_APPEND:   cmd_o.append    = 1'b1;
      ST_SCAN:     cmd_o.scan      = 1'b1;
      ST_SCAN_END: cmd_o.div_load  = 1'b1;
      ST_DIV:      cmd_o.div_step  = 1'b1;
      ST_DONE:     cmd_o.out_load  = status_i.out_free;
      default:     cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  `TWPT_ASSERT_NEXT(a_done_to_idle, state_q == ST_DONE && status_i.out_free,
                    state_q == ST_IDLE, "result not released")
  `TWPT_ASSERT_NEXT(a_append_to_scan, state_q == ST_APPEND, state_q == ST_SCAN,
                    "append not followed by scan")
  `TWPT_ASSERT(a_one_phase, $onehot0({cmd_o.drop, cmd_o.append, cmd_o.scan, cmd_o.div_step}),
               "overlapping datapath phases")

endmodule

`default_nettype wire

>>> hw/rtl/time_window_peak_tracker_top.sv
// Top level of the time window peak tracker: joins controller and datapath.
// Uses twpt_pkg, twpt_ctrl and twpt_datapath.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries a clear command or a
//   timestamped Q16.16 sample. Output channel out_valid_o / out_stall_i /
//   out_data_o returns one result (peak, its timestamp, mean, count) per item.
//   The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) sets the window
//   length and the ring capacity; a capacity write also empties the ring.
// Timing:
//   One item at a time. A sample passes through the drop of each aged entry (read,
//   then check), the append, a scan of the N entries held after the append and
//   the SUM_W (43) divider steps, then waits for the output register; a clear
//   goes straight to the output register. The next item is accepted in the cycle
//   in which the result becomes valid.
// Reset:
//   Asynchronous, active low; the ring is empty, window 60000 ms, capacity 1024.
//   No memory clearing pass is needed.
// Back-pressure:
//   A finished result waits in the output register while out_stall_i is high;
//   the next item is accepted meanwhile, and its result waits in turn.
`default_nettype none

module time_window_peak_tracker_top (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [twpt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [twpt_pkg::WIN_W-1:0]     cfg_data_i,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  twpt_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output twpt_pkg::out_item_t           out_data_o
);
  import twpt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer
  twpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic
  twpt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
